/* rtl/core/closest_point_on_segment_core_defines.svh */
// Assertion macros used by the port checker of the segment core.
`ifndef CLOSEST_POINT_ON_SEGMENT_CORE_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define CPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("segment core assertion failed");

// Implication into the next cycle, outside reset.
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("segment core assertion failed");

// Property checked at every edge, reset included.
`define CPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("segment core assertion failed");

`endif

/* rtl/core/cps_pkg.sv */
// Shared types and constants of the closest-point-on-segment core.
package cps_pkg;

    localparam int COORD_W   = 24;
    localparam int CFG_IDX_W = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] nearest_x;
        logic signed [COORD_W-1:0] nearest_y;
    } nearest_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 2'd0,
        REG_START_Y = 2'd1,
        REG_END_X   = 2'd2,
        REG_END_Y   = 2'd3
    } reg_idx_t;

    // Which answer an item takes.
    typedef enum logic [2:0] {
        SEL_START = 3'b001,
        SEL_END   = 3'b010,
        SEL_MID   = 3'b100
    } sel_t;

    typedef struct packed {
        logic valid;
        sel_t sel;
    } ctl_t;

endpackage

/* rtl/core/cps_div_step.sv */
// One restoring division step: shift in a numerator bit, subtract if it fits.
module cps_div_step
    import cps_pkg::*;
#(
    parameter int LW = 50,
    parameter int N  = 25
)
(
    input  logic [LW-1:0] rem_in,
    input  logic [N-1:0]  low_in,
    input  logic [LW-1:0] den,
    output logic [LW-1:0] rem_out,
    output logic [N-1:0]  low_out
);

    logic [LW:0] trial;
    logic [LW:0] diff;
    logic        ge;

    always_comb
    begin
        trial   = {rem_in, low_in[N-1]};
        diff    = trial - {1'b0, den};
        ge      = (trial >= {1'b0, den});
        rem_out = ge ? diff[LW-1:0] : trial[LW-1:0];
        // quotient bits enter where numerator bits leave
        low_out = {low_in[N-2:0], ge};
    end

endmodule

/* rtl/core/cps_divider.sv */
// Pipelined restoring divider for both axes, one quotient bit per stage.
module cps_divider
    import cps_pkg::*;
#(
    parameter int LW = 50,
    parameter int N  = 25
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ctl_t          in_ctl,
    input  logic [LW-1:0] in_rem_x,
    input  logic [N-1:0]  in_low_x,
    input  logic [LW-1:0] in_rem_y,
    input  logic [N-1:0]  in_low_y,
    input  logic [LW-1:0] len2,
    output ctl_t          out_ctl,
    output logic [LW-1:0] out_rem_x,
    output logic [N-1:0]  out_low_x,
    output logic [LW-1:0] out_rem_y,
    output logic [N-1:0]  out_low_y
);

    ctl_t          ctl_reg   [N];
    logic [LW-1:0] rem_x_reg [N];
    logic [N-1:0]  low_x_reg [N];
    logic [LW-1:0] rem_y_reg [N];
    logic [N-1:0]  low_y_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        ctl_t          ctl_prev;
        logic [LW-1:0] rx_prev, ry_prev, rx_next, ry_next;
        logic [N-1:0]  lx_prev, ly_prev, lx_next, ly_next;

        if (i == 0)
        begin : g_first
            assign ctl_prev = in_ctl;
            assign rx_prev  = in_rem_x;
            assign lx_prev  = in_low_x;
            assign ry_prev  = in_rem_y;
            assign ly_prev  = in_low_y;
        end
        else
        begin : g_rest
            assign ctl_prev = ctl_reg[i-1];
            assign rx_prev  = rem_x_reg[i-1];
            assign lx_prev  = low_x_reg[i-1];
            assign ry_prev  = rem_y_reg[i-1];
            assign ly_prev  = low_y_reg[i-1];
        end

        cps_div_step #(.LW(LW), .N(N)) u_step_x
        (
            .rem_in  (rx_prev),
            .low_in  (lx_prev),
            .den     (len2),
            .rem_out (rx_next),
            .low_out (lx_next)
        );

        cps_div_step #(.LW(LW), .N(N)) u_step_y
        (
            .rem_in  (ry_prev),
            .low_in  (ly_prev),
            .den     (len2),
            .rem_out (ry_next),
            .low_out (ly_next)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '{valid: 1'b0, sel: SEL_START};
            end
            else if (en)
            begin
                ctl_reg[i] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_x_reg[i] <= rx_next;
                low_x_reg[i] <= lx_next;
                rem_y_reg[i] <= ry_next;
                low_y_reg[i] <= ly_next;
            end
        end
    end

    assign out_ctl   = ctl_reg[N-1];
    assign out_rem_x = rem_x_reg[N-1];
    assign out_low_x = low_x_reg[N-1];
    assign out_rem_y = rem_y_reg[N-1];
    assign out_low_y = low_y_reg[N-1];

endmodule

/* rtl/core/closest_point_on_segment_core.sv */
// Top level of the closest-point-on-segment core.
//
// Usage: write the segment endpoints through the cfg channel (index 0 start_x,
// 1 start_y, 2 end_x, 3 end_y, signed Q16.8); cfg_ready is always high. Write
// only while no query is in flight. Queries enter on in_valid/in_ready, one
// transfer per target point, and each gives exactly one transfer on
// out_valid/out_ready carrying the nearest point of the segment.
//
// Throughput: one query per cycle while the output does not stall. Stages from
// the accepting edge to out_valid: four front stages (offset, products, dot sum,
// classify with numerator products), one stage that forms the first partial
// remainder, then one restoring division step per quotient bit, COORD_W + 1
// stages, shared by nothing, then the rounding and output register. The
// quotient length sets the depth.
//
// Reset clears all valid bits and the endpoint registers to zero. When a
// result waits at the output and the receiver stalls, the whole pipeline
// holds, bubbles included, and in_ready drops until that result transfers.
module closest_point_on_segment_core
    import cps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  point_t               in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nearest_t             out_data
);

    localparam int W  = COORD_W;
    localparam int DW = W + 1;      // differences and offsets
    localparam int PW = 2 * DW;     // products
    localparam int DOTW = PW + 1;   // dot product, signed
    localparam int LW = PW;         // squared length, unsigned
    localparam int N  = DW;         // quotient bits

    // Endpoint registers
    logic signed [W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ex_reg <= '0;
            ey_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START_X: sx_reg <= cfg_data;
                REG_START_Y: sy_reg <= cfg_data;
                REG_END_X:   ex_reg <= cfg_data;
                REG_END_Y:   ey_reg <= cfg_data;
                default:     sx_reg <= sx_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Segment terms, refreshed every cycle. They settle well before any
    // query that follows a write reaches the stage that reads them.
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0] sqx_reg, sqy_reg;
    logic [LW-1:0]        len2_reg;
    logic [DW-1:0]        mx, my;

    always_ff @(posedge clk)
    begin
        dx_reg   <= DW'(ex_reg) - DW'(sx_reg);
        dy_reg   <= DW'(ey_reg) - DW'(sy_reg);
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        len2_reg <= LW'(sqx_reg) + LW'(sqy_reg);
    end

    assign mx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign my = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    // Global advance: everything moves unless a result is stuck at the output.
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Front pipeline
    logic                 v1_reg, v2_reg, v3_reg;
    ctl_t                 ctl4_reg, ctl5_reg;
    logic signed [DW-1:0] tx1_reg, ty1_reg;
    logic signed [PW-1:0] px2_reg, py2_reg;
    logic signed [DOTW-1:0] dot3_reg;
    logic [PW-1:0]        plx4_reg, phx4_reg, ply4_reg, phy4_reg;
    logic [LW-1:0]        remx5_reg, remy5_reg;
    logic [N-1:0]         lowx5_reg, lowy5_reg;

    sel_t                 sel4_next;
    logic [LW-1:0]        dot_u;

    always_comb
    begin
        dot_u = dot3_reg[LW-1:0];
        if (len2_reg == '0 || dot3_reg <= 0)
        begin
            sel4_next = SEL_START;
        end
        else if (dot3_reg >= $signed({1'b0, len2_reg}))
        begin
            sel4_next = SEL_END;
        end
        else
        begin
            sel4_next = SEL_MID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ctl4_reg <= '{valid: 1'b0, sel: SEL_START};
            ctl5_reg <= '{valid: 1'b0, sel: SEL_START};
        end
        else if (adv)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            ctl4_reg <= '{valid: v3_reg, sel: sel4_next};
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx1_reg   <= DW'(in_data.target_x) - DW'(sx_reg);
            ty1_reg   <= DW'(in_data.target_y) - DW'(sy_reg);
            px2_reg   <= tx1_reg * dx_reg;
            py2_reg   <= ty1_reg * dy_reg;
            dot3_reg  <= DOTW'(px2_reg) + DOTW'(py2_reg);
            // split the dot product so each multiply stays one word wide
            plx4_reg  <= dot_u[N-1:0] * mx;
            phx4_reg  <= dot_u[LW-1:N] * mx;
            ply4_reg  <= dot_u[N-1:0] * my;
            phy4_reg  <= dot_u[LW-1:N] * my;
            remx5_reg <= phx4_reg + {{N{1'b0}}, plx4_reg[PW-1:N]};
            lowx5_reg <= plx4_reg[N-1:0];
            remy5_reg <= phy4_reg + {{N{1'b0}}, ply4_reg[PW-1:N]};
            lowy5_reg <= ply4_reg[N-1:0];
        end
    end

    // Division
    ctl_t          ctl_d;
    logic [LW-1:0] rem_xd, rem_yd;
    logic [N-1:0]  q_xd, q_yd;

    cps_divider #(.LW(LW), .N(N)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_ctl    (ctl5_reg),
        .in_rem_x  (remx5_reg),
        .in_low_x  (lowx5_reg),
        .in_rem_y  (remy5_reg),
        .in_low_y  (lowy5_reg),
        .len2      (len2_reg),
        .out_ctl   (ctl_d),
        .out_rem_x (rem_xd),
        .out_low_x (q_xd),
        .out_rem_y (rem_yd),
        .out_low_y (q_yd)
    );

    // Round half away from zero, then step from start along d.
    logic [DW:0]  qx_r, qy_r;
    logic [DW:0]  rx_full, ry_full;
    nearest_t     res_next;
    nearest_t     out_data_reg;

    always_comb
    begin
        qx_r = {1'b0, q_xd} + (DW+1)'({rem_xd, 1'b0} >= {1'b0, len2_reg});
        qy_r = {1'b0, q_yd} + (DW+1)'({rem_yd, 1'b0} >= {1'b0, len2_reg});
        rx_full = dx_reg[DW-1] ? (DW+1)'(sx_reg) - qx_r : (DW+1)'(sx_reg) + qx_r;
        ry_full = dy_reg[DW-1] ? (DW+1)'(sy_reg) - qy_r : (DW+1)'(sy_reg) + qy_r;
        case (ctl_d.sel)
            SEL_END:
            begin
                res_next.nearest_x = ex_reg;
                res_next.nearest_y = ey_reg;
            end
            SEL_MID:
            begin
                res_next.nearest_x = rx_full[W-1:0];
                res_next.nearest_y = ry_full[W-1:0];
            end
            default:
            begin
                res_next.nearest_x = sx_reg;
                res_next.nearest_y = sy_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/cps_checker.sv */
// Port-level checks of the segment core and the bind that attaches them.
`include "closest_point_on_segment_core_defines.svh"

module cps_checker
    import cps_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_ready,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input nearest_t             out_data
);

    // A stalled result holds.
    `CPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // Input side is held back only by a result waiting at the output.
    `CPS_ASSERT(a_in_ready, clk, rst_n, in_ready == (!out_valid || out_ready))

    // Register writes are never refused.
    `CPS_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready)

    // Nothing is offered right as reset is released.
    `CPS_ASSERT_ALWAYS(a_reset_quiet, clk, !$rose(rst_n) || !out_valid)

endmodule

bind closest_point_on_segment_core cps_checker u_cps_checker (.*);

/* tb/closest_point_on_segment_core_tb.sv */
// Testbench for the closest-point-on-segment core: random and directed queries checked
// against an in-bench predictor.
`timescale 1ns / 100ps

module closest_point_on_segment_core_tb;
    import cps_pkg::*;

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
    // Idle time after the last result, longer than the core's pipeline.
    localparam int SETTLE_CYCLES = COORD_W + 16;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    point_t               in_data;
    logic                 out_valid;
    logic                 out_ready;
    nearest_t             out_data;

    // Shadow copy of the endpoint registers.
    logic signed [COORD_W-1:0] seg_sx, seg_sy, seg_ex, seg_ey;

    // Results the core still owes us, oldest first.
    nearest_t pending_nearest[$];
    int       mismatch_count;
    int       failure_count;

    // Control of the receiver side.
    bit quiet_mode;     // no idling on either side
    int hold_cycles;    // requested long hold-off of out_ready
    int stall_left;

    closest_point_on_segment_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One axis of the interior case: s + dot*d/len2, rounded half away from zero.
    function automatic logic [COORD_W-1:0] project_axis(longint s, longint d,
                                                        longint dot, longint len2);
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        longint       mag_d;
        longint       res;
        mag_d = (d < 0) ? -d : d;
        num = 128'(dot) * 128'(mag_d);
        quo = num / 128'(len2);
        rem = num % 128'(len2);
        // Round on the magnitude; the sign of d is applied afterwards.
        if ((rem << 1) >= 128'(len2))
            quo = quo + 1;
        res = (d < 0) ? s - longint'(quo) : s + longint'(quo);
        return res[COORD_W-1:0];
    endfunction

    function automatic nearest_t nearest_on_segment(point_t p);
        longint   sx, sy, ex, ey, dx, dy, tx, ty, dot, len2;
        nearest_t r;
        sx = longint'(seg_sx);
        sy = longint'(seg_sy);
        ex = longint'(seg_ex);
        ey = longint'(seg_ey);
        dx = ex - sx;
        dy = ey - sy;
        tx = longint'(p.target_x) - sx;
        ty = longint'(p.target_y) - sy;
        // All terms fit comfortably in 64 bits at this coordinate width.
        dot  = tx * dx + ty * dy;
        len2 = dx * dx + dy * dy;
        if (len2 == 0 || dot <= 0) begin
            r.nearest_x = seg_sx;
            r.nearest_y = seg_sy;
        end
        else if (dot >= len2) begin
            r.nearest_x = seg_ex;
            r.nearest_y = seg_ey;
        end
        else begin
            r.nearest_x = project_axis(sx, dx, dot, len2);
            r.nearest_y = project_axis(sy, dy, dot, len2);
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Transfer one register write; valid stays up for back-to-back writes.
    task automatic write_reg(reg_idx_t idx, logic [COORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_START_X: seg_sx = value;
            REG_START_Y: seg_sy = value;
            REG_END_X:   seg_ex = value;
            REG_END_Y:   seg_ey = value;
            default: ;
        endcase
    endtask

    // Load a new segment; only called with nothing in flight.
    task automatic set_segment(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                               logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        cfg_valid <= 1'b0;
    endtask

    // Transfer one query; in_valid stays high unless the sender idles first.
    task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        point_t p;
        p.target_x = x;
        p.target_y = y;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
        pending_nearest.push_back(nearest_on_segment(p));
    endtask

    // Drop valid and wait until every result is back, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A point near the segment line, from before start to past end, with noise.
    task automatic send_near_segment();
        longint k, px, py;
        k  = longint'($urandom_range(0, 24)) - 4;
        px = longint'(seg_sx) + ((longint'(seg_ex) - longint'(seg_sx)) * k) / 16;
        py = longint'(seg_sy) + ((longint'(seg_ey) - longint'(seg_sy)) * k) / 16;
        px = px + longint'($urandom_range(0, 1024)) - 512;
        py = py + longint'($urandom_range(0, 1024)) - 512;
        send_point(clamp_coord(px), clamp_coord(py));
    endtask

    task automatic random_segment();
        logic [COORD_W-1:0] sx, sy, ex, ey;
        case ($urandom_range(0, 4))
            0: begin
                // Full range endpoints.
                sx = rand_coord(); sy = rand_coord();
                ex = rand_coord(); ey = rand_coord();
            end
            1: begin
                // Short segment near the origin: rounding matters most here.
                sx = clamp_coord(longint'($urandom_range(0, 64)) - 32);
                sy = clamp_coord(longint'($urandom_range(0, 64)) - 32);
                ex = clamp_coord(longint'($urandom_range(0, 64)) - 32);
                ey = clamp_coord(longint'($urandom_range(0, 64)) - 32);
            end
            2: begin
                // Axis aligned.
                sx = rand_coord(); sy = rand_coord();
                ex = ($urandom_range(0, 1) != 0) ? sx : rand_coord();
                ey = (ex == sx) ? rand_coord() : sy;
            end
            3: begin
                // Zero length.
                sx = rand_coord(); sy = rand_coord();
                ex = sx; ey = sy;
            end
            default: begin
                sx = clamp_coord(longint'($urandom_range(0, 8000)) - 4000);
                sy = clamp_coord(longint'($urandom_range(0, 8000)) - 4000);
                ex = clamp_coord(longint'($urandom_range(0, 8000)) - 4000);
                ey = clamp_coord(longint'($urandom_range(0, 8000)) - 4000);
            end
        endcase
        set_segment(sx, sy, ex, ey);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls in bursts, a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_cycles > 0) begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (quiet_mode) begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        nearest_t exp_n;
        if (rst_n && out_valid && out_ready) begin
            if (pending_nearest.size() == 0) begin
                failure_count++;
                if (mismatch_count < 10)
                    $display("ERROR: unexpected result x=%0d y=%0d",
                             out_data.nearest_x, out_data.nearest_y);
                mismatch_count++;
            end
            else begin
                exp_n = pending_nearest.pop_front();
                if (out_data.nearest_x !== exp_n.nearest_x ||
                    out_data.nearest_y !== exp_n.nearest_y) begin
                    failure_count++;
                    if (mismatch_count < 10)
                        $display("ERROR: nearest mismatch exp (%0d,%0d) got (%0d,%0d)",
                                 exp_n.nearest_x, exp_n.nearest_y,
                                 out_data.nearest_x, out_data.nearest_y);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers reset to zero: a zero-length segment at the origin.
    task automatic test_reset_segment();
        send_point(rand_coord(), rand_coord());
        send_point(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
        drain_results();
    endtask

    task automatic test_directed_cases();
        // Diagonal unit segment: half-way ties round away from zero.
        set_segment(0, 0, 1, 1);
        send_point(1, 0);
        send_point(0, 1);
        send_point(-5, -5);   // before start
        send_point(9, 9);     // past end
        drain_results();
        // Reversed direction: rounding on negative deltas.
        set_segment(1, 1, 0, 0);
        send_point(0, 1);
        send_point(1, 0);
        drain_results();
        // Horizontal segment, interior and both ends.
        set_segment(-256, 512, 768, 512);
        send_point(0, 100000);
        send_point(-256, 0);
        send_point(768, -99);
        send_point(300, 512);
        drain_results();
        // Zero length away from the origin.
        set_segment(1234, -4321, 1234, -4321);
        send_point(0, 0);
        send_point(COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
        drain_results();
    endtask

    // Endpoints at the corners of the coordinate range.
    task automatic test_extreme_segment();
        set_segment(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN),
                    COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
        send_point(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
        send_point(COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
        send_point(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
        send_point(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
        send_point(0, 1);
        drain_results();
        set_segment(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN),
                    COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
        send_point(0, 0);
        send_point(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
        send_point(-1, 0);
        drain_results();
    endtask

    task automatic test_random_segments(int n_segments, int n_points);
        repeat (n_segments) begin
            random_segment();
            repeat (n_points) begin
                if ($urandom_range(0, 2) == 0)
                    send_point(rand_coord(), rand_coord());
                else
                    send_near_segment();
            end
            drain_results();
        end
    endtask

    // Hold the output off long enough to fill the pipe and stall in_ready.
    task automatic test_output_backpressure();
        random_segment();
        hold_cycles = 200;
        repeat (80) send_near_segment();
        drain_results();
    endtask

    // Tail of the run: full rate on both sides.
    task automatic test_full_rate_stream();
        quiet_mode = 1'b1;
        random_segment();
        repeat (200) send_near_segment();
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        seg_sx         = '0;
        seg_sy         = '0;
        seg_ex         = '0;
        seg_ey         = '0;
        mismatch_count = 0;
        failure_count  = 0;
        quiet_mode     = 1'b0;
        hold_cycles    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_segment();
        test_directed_cases();
        test_extreme_segment();
        test_random_segments(10, 100);
        test_output_backpressure();
        test_random_segments(3, 40);
        test_full_rate_stream();

        if (pending_nearest.size() != 0)
            failure_count++;
        if (failure_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
